>>> design/hill_cipher_encryptor_defines.svh
// assertion macros for the hill cipher encryptor
// no dependencies; included by files that carry concurrent assertions
`ifndef HILL_CIPHER_ENCRYPTOR_DEFINES_SVH
`define HILL_CIPHER_ENCRYPTOR_DEFINES_SVH

// condition holds at every edge out of reset
`define HCE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define HCE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/hce_pkg.sv
// shared constants, types and helpers of the hill cipher encryptor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hce_pkg;

    localparam int MAX_KEY_SIZE = 9;
    localparam int MIN_KEY_SIZE = 2;

    localparam int MODE_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int KEY_IDX_W  = 4;
    localparam int KEY_VAL_W  = 5;
    localparam int KEY_SIZE_W = 4;
    localparam int CHAR_W     = 7;
    localparam int LETTER_W   = 5;

    localparam int IDX_W     = $clog2(MAX_KEY_SIZE);
    localparam int CNT_W     = $clog2(MAX_KEY_SIZE + 1);
    localparam int KEY_DEPTH = MAX_KEY_SIZE * MAX_KEY_SIZE;
    localparam int KEY_AW    = $clog2(KEY_DEPTH);

    localparam int ALPHA         = 26;
    localparam int LETTER_A      = 97;
    localparam int LETTER_Z      = 122;
    localparam int ASCII_UPPER_A = 65;
    localparam int ASCII_UPPER_Z = 90;
    localparam int PAD_LETTER    = 23;

    localparam int MAX_SUM     = MAX_KEY_SIZE * ((1 << KEY_VAL_W) - 1) * (ALPHA - 1);
    localparam int SUM_W       = $clog2(MAX_SUM + 1);
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + ALPHA - 1) / ALPHA;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int MUL_W       = SUM_W + RECIP_W;
    localparam int QUOT_W      = $clog2(MAX_SUM / ALPHA + 1);

    localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_KEY   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd2;

    typedef logic [KEY_AW-1:0]   t_key_addr;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [LETTER_W-1:0] t_letter;

    function automatic t_key_addr key_addr(input logic [KEY_IDX_W-1:0] row,
                                           input logic [KEY_IDX_W-1:0] col);
        return t_key_addr'(row) * t_key_addr'(MAX_KEY_SIZE) + t_key_addr'(col);
    endfunction

endpackage

`default_nettype wire

>>> design/hce_if.sv
// item channels of the hill cipher encryptor: input items and cipher letters
// depends on hce_pkg
`timescale 1ns / 1ps
`default_nettype none

interface hce_in_if import hce_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [BYTE_W-1:0]    text_byte;
    logic [KEY_IDX_W-1:0] key_row;
    logic [KEY_IDX_W-1:0] key_col;
    logic [KEY_VAL_W-1:0] key_value;

    modport source (output valid, mode, text_byte, key_row, key_col, key_value,
                    input ready);
    modport sink   (input valid, mode, text_byte, key_row, key_col, key_value,
                    output ready);
endinterface

interface hce_out_if import hce_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cipher_char;
    logic              block_end;

    modport source (output valid, cipher_char, block_end, input ready);
    modport sink   (input valid, cipher_char, block_end, output ready);
endinterface

`default_nettype wire

>>> design/hill_cipher_encryptor.sv
// Hill cipher encryptor (mod 26). Text, key-write and flush items arrive on i_in;
// cipher letters leave on o_out, block_end marking the last letter of a block.
// An item that completes a block of n letters holds the input until the last
// cipher letter is registered for o_out, stalls on o_out included: each row reads
// its n key entries from the key RAM, one read per cycle, into the single
// multiply-accumulate, then passes S_SUM (last accumulate), S_DIV and S_MOD
// (mod-26 reduction by reciprocal multiply). The key RAM has a valid flag per
// entry, so it is usable straight after reset with no clearing pass. The user
// writes key_size through i_cfg_we / i_cfg_data only while idle; the block
// itself does not enforce it.
// depends on hce_pkg, hce_if and hill_cipher_encryptor_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "hill_cipher_encryptor_defines.svh"

module hill_cipher_encryptor import hce_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [KEY_SIZE_W-1:0] i_cfg_data,
    hce_in_if.sink                     i_in,
    hce_out_if.source                  o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [KEY_SIZE_W-1:0] r_key_size;
    logic [CNT_W-1:0]      r_fill;
    logic [CNT_W-1:0]      r_n;
    logic [IDX_W-1:0]      r_row;
    logic [IDX_W-1:0]      r_col;
    logic [IDX_W-1:0]      r_rd_col;
    logic                  r_rd_vld;

    logic [KEY_VAL_W-1:0]  r_key_mem [0:KEY_DEPTH-1];
    logic [KEY_DEPTH-1:0]  r_key_vld;
    logic [KEY_VAL_W-1:0]  r_key_rdata;
    logic                  r_key_rvld;

    t_letter               r_buf [0:MAX_KEY_SIZE-1];
    t_sum                  r_sum;
    logic [QUOT_W-1:0]     r_quot;

    logic                  r_out_vld;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_end;

    logic                  in_fire;
    logic                  is_upper;
    logic                  is_lower;
    logic                  text_wr;
    logic [BYTE_W-1:0]     byte_off;
    t_letter               letter;
    logic [CNT_W-1:0]      blk_n;
    logic [CNT_W-1:0]      fill_inc;
    logic                  start_text;
    logic                  start_flush;
    logic                  blk_start;
    logic                  key_we;
    t_key_addr             wr_addr;
    t_key_addr             rd_addr;
    t_sum                  prod;
    logic                  last_col;
    logic                  last_row;
    logic                  out_free;
    logic                  advance;
    logic [MUL_W-1:0]      mul_full;
    t_sum                  rem_full;

    // input decode
    assign in_fire    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign is_upper = (i_in.text_byte >= BYTE_W'(ASCII_UPPER_A)) &&
                      (i_in.text_byte <= BYTE_W'(ASCII_UPPER_Z));
    assign is_lower = (i_in.text_byte >= BYTE_W'(LETTER_A)) &&
                      (i_in.text_byte <= BYTE_W'(LETTER_Z));
    assign byte_off = is_upper ? i_in.text_byte - BYTE_W'(ASCII_UPPER_A)
                               : i_in.text_byte - BYTE_W'(LETTER_A);
    assign letter   = byte_off[LETTER_W-1:0];

    always_comb begin
        if (r_key_size < KEY_SIZE_W'(MIN_KEY_SIZE)) begin
            blk_n = CNT_W'(MIN_KEY_SIZE);
        end else if (32'(r_key_size) > 32'(MAX_KEY_SIZE)) begin
            blk_n = CNT_W'(MAX_KEY_SIZE);
        end else begin
            blk_n = CNT_W'(r_key_size);
        end
    end

    assign fill_inc    = r_fill + CNT_W'(1);
    assign text_wr     = in_fire && (i_in.mode == MODE_TEXT) && (is_upper || is_lower);
    assign start_text  = text_wr && (fill_inc >= blk_n);
    assign start_flush = in_fire && (i_in.mode == MODE_FLUSH) && (r_fill != '0);
    assign blk_start   = start_text || start_flush;
    assign key_we      = in_fire && (i_in.mode == MODE_KEY) &&
                         (32'(i_in.key_row) < 32'(MAX_KEY_SIZE)) &&
                         (32'(i_in.key_col) < 32'(MAX_KEY_SIZE));
    assign wr_addr     = key_addr(i_in.key_row, i_in.key_col);
    assign rd_addr     = key_addr(KEY_IDX_W'(r_row), KEY_IDX_W'(r_col));

    // datapath
    assign prod     = (r_key_rvld ? t_sum'(r_key_rdata) : '0) * t_sum'(r_buf[r_rd_col]);
    assign last_col = (r_col == IDX_W'(r_n - CNT_W'(1)));
    assign last_row = (r_row == IDX_W'(r_n - CNT_W'(1)));
    assign out_free = !r_out_vld || o_out.ready;
    assign advance  = (r_state == S_MOD) && out_free;
    assign mul_full = MUL_W'(r_sum) * MUL_W'(RECIP);
    assign rem_full = r_sum - t_sum'(r_quot) * t_sum'(ALPHA);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (blk_start) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (last_col) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: n_state = S_DIV;
            S_DIV: n_state = S_MOD;
            S_MOD: begin
                if (out_free) begin
                    n_state = last_row ? S_IDLE : S_MAC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_key_size <= KEY_SIZE_W'(MIN_KEY_SIZE);
            r_fill     <= '0;
            r_rd_vld   <= 1'b0;
            r_key_vld  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_MAC);
            if (i_cfg_we) begin
                r_key_size <= i_cfg_data;
            end
            if (blk_start) begin
                r_fill <= '0;
            end else if (text_wr) begin
                r_fill <= fill_inc;
            end
            if (key_we) begin
                r_key_vld[wr_addr] <= 1'b1;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // key ram
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key_mem[wr_addr] <= i_in.key_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key_rdata <= r_key_mem[rd_addr];
        r_key_rvld  <= r_key_vld[rd_addr];
    end

    // letter buffer, sequencer counters and accumulator
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_KEY_SIZE; i++) begin
            if (text_wr && (r_fill == CNT_W'(i))) begin
                r_buf[i] <= letter;
            end else if (start_flush && (CNT_W'(i) >= r_fill) && (CNT_W'(i) < blk_n)) begin
                r_buf[i] <= t_letter'(PAD_LETTER);
            end
        end

        r_rd_col <= r_col;

        if (blk_start) begin
            r_n   <= blk_n;
            r_row <= '0;
            r_col <= '0;
        end else if (r_state == S_MAC && !last_col) begin
            r_col <= r_col + IDX_W'(1);
        end else if (advance) begin
            r_col <= '0;
            r_row <= r_row + IDX_W'(1);
        end

        if (r_state == S_IDLE || advance) begin
            r_sum <= '0;
        end else if (r_rd_vld) begin
            r_sum <= r_sum + prod;
        end

        if (r_state == S_DIV) begin
            r_quot <= QUOT_W'(mul_full >> RECIP_SHIFT);
        end

        if (advance) begin
            r_out_char <= CHAR_W'(LETTER_A) + CHAR_W'(rem_full[LETTER_W-1:0]);
            r_out_end  <= last_row;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.cipher_char = r_out_char;
    assign o_out.block_end   = r_out_end;

    // checks
    `HCE_ASSERT_ALWAYS(a_fill_bound, i_clk, i_rst_n, 32'(r_fill) <= 32'(MAX_KEY_SIZE), "fill count above block limit")
    `HCE_ASSERT_IMPLY(a_fill_clear, i_clk, i_rst_n, r_state != S_IDLE, r_fill == '0, "letters held while a block is emitted")
    `HCE_ASSERT_IMPLY(a_rd_window, i_clk, i_rst_n, r_rd_vld, (r_state == S_MAC) || (r_state == S_SUM), "key read data outside the accumulate window")
    `HCE_ASSERT_IMPLY(a_mod_range, i_clk, i_rst_n, r_state == S_MOD, 32'(rem_full) < 32'(ALPHA), "mod-26 reduction out of range")

endmodule

`default_nettype wire
